>>> src/brl_pkg.sv
package brl_pkg;

	// Fixed field widths of the command and result items
	localparam int COORD_W  = 8;
	localparam int COLOUR_W = 32;
	localparam int CNT_W    = 3;
	localparam int HW_LANES = 4;
	// Pixel count of a line: up to 2**COORD_W, needs one extra bit
	localparam int REMAIN_W = COORD_W + 1;
	// Signed error term: spans -(2**COORD_W - 1) .. (2**COORD_W - 1)
	localparam int ERR_W    = COORD_W + 2;

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [COLOUR_W-1:0] colour_t;
	typedef logic [CNT_W-1:0]    count_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the command item
		logic setup;  // derive axes, deltas and start error
		logic step;   // emit one pixel group and advance
	} brl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_group;  // the group now being stepped ends the line
	} brl_status_t;

	// Pixels per group: LANES clamped to the hardware lanes
	function automatic int brl_group(input int lanes);
		int g;
		g = lanes;
		if (g < 1) g = 1;
		if (g > HW_LANES) g = HW_LANES;
		return g;
	endfunction

endpackage

>>> src/brl_ctrl.sv
module brl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  brl_pkg::brl_status_t status,
	output brl_pkg::brl_cmd_t    cmd,
	output logic                busy
);
	import brl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   busy_q;

	// Issue datapath commands from the current state
	always_comb begin
		cmd.load  = start && (state_q == ST_IDLE);
		cmd.setup = (state_q == ST_SETUP);
		cmd.step  = (state_q == ST_RUN);
	end

	// Hold state and the busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
						busy_q  <= 1'b1;
					end
				end
				ST_SETUP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (status.last_group) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

>>> src/brl_datapath.sv
module brl_datapath #(
	parameter int COORD_BITS = 8,
	parameter int LANES      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brl_pkg::brl_cmd_t     cmd,
	output brl_pkg::brl_status_t  status,
	input  brl_pkg::coord_t       start_x,
	input  brl_pkg::coord_t       start_y,
	input  brl_pkg::coord_t       end_x,
	input  brl_pkg::coord_t       end_y,
	input  brl_pkg::colour_t      pixel_value,
	output brl_pkg::coord_t       lane_x [brl_pkg::HW_LANES],
	output brl_pkg::coord_t       lane_y [brl_pkg::HW_LANES],
	output brl_pkg::count_t       pixel_count,
	output brl_pkg::colour_t      colour_out,
	output logic                  is_last,
	output logic                  result_valid
);
	import brl_pkg::*;

	localparam int GROUP = brl_group(LANES);
	localparam coord_t COORD_MASK = (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
		COORD_W'((1 << COORD_BITS) - 1);

	// Captured command
	coord_t  ax_q, ay_q, bx_q, by_q;
	colour_t colour_q;

	// Walk state
	logic                    steep_q;
	logic                    min_down_q;
	coord_t                  maj_q, min_q;
	coord_t                  dx_q, dy_q;
	logic signed [ERR_W-1:0] err_q;
	logic [REMAIN_W-1:0]     remain_q;

	// Setup logic
	coord_t adx, ady, a_maj, a_min, b_maj, b_min;
	coord_t s_maj0, s_min0, s_maj1, s_min1;
	logic   s_steep;

	// Group logic
	coord_t                  g_x [HW_LANES];
	coord_t                  g_y [HW_LANES];
	coord_t                  g_maj, g_min;
	logic signed [ERR_W-1:0] g_err;
	count_t                  g_cnt;
	logic                    g_last;

	// Output registers
	coord_t  lane_x_q [HW_LANES];
	coord_t  lane_y_q [HW_LANES];
	count_t  count_q;
	colour_t colour_out_q;
	logic    last_q;
	logic    valid_q;

	// Order the endpoints along the major axis
	always_comb begin
		adx     = (bx_q > ax_q) ? bx_q - ax_q : ax_q - bx_q;
		ady     = (by_q > ay_q) ? by_q - ay_q : ay_q - by_q;
		s_steep = ady > adx;
		a_maj   = s_steep ? ay_q : ax_q;
		a_min   = s_steep ? ax_q : ay_q;
		b_maj   = s_steep ? by_q : bx_q;
		b_min   = s_steep ? bx_q : by_q;
		if (a_maj > b_maj) begin
			s_maj0 = b_maj;
			s_min0 = b_min;
			s_maj1 = a_maj;
			s_min1 = a_min;
		end else begin
			s_maj0 = a_maj;
			s_min0 = a_min;
			s_maj1 = b_maj;
			s_min1 = b_min;
		end
	end

	// Step up to GROUP pixels of the line
	always_comb begin
		g_maj = maj_q;
		g_min = min_q;
		g_err = err_q;
		g_cnt = '0;
		for (int k = 0; k < HW_LANES; k++) begin
			g_x[k] = '0;
			g_y[k] = '0;
			if ((k < GROUP) && (REMAIN_W'(k) < remain_q)) begin
				g_x[k] = steep_q ? g_min : g_maj;
				g_y[k] = steep_q ? g_maj : g_min;
				g_err  = g_err - $signed({2'b00, dy_q});
				if (g_err < 0) begin
					g_min = min_down_q ? g_min - 1'b1 : g_min + 1'b1;
					g_err = g_err + $signed({2'b00, dx_q});
				end
				g_maj = g_maj + 1'b1;
				g_cnt = g_cnt + 1'b1;
			end
		end
		g_last = remain_q <= REMAIN_W'(GROUP);
	end

	assign status.last_group = g_last;

	// Capture the command, set up and advance the walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q     <= start_x & COORD_MASK;
			ay_q     <= start_y & COORD_MASK;
			bx_q     <= end_x & COORD_MASK;
			by_q     <= end_y & COORD_MASK;
			colour_q <= pixel_value;
		end
		if (cmd.setup) begin
			steep_q    <= s_steep;
			maj_q      <= s_maj0;
			min_q      <= s_min0;
			min_down_q <= !(s_min0 < s_min1);
			dx_q       <= s_maj1 - s_maj0;
			dy_q       <= (s_min1 > s_min0) ? s_min1 - s_min0 : s_min0 - s_min1;
			err_q      <= $signed({2'b00, (s_maj1 - s_maj0) >> 1});
			remain_q   <= {1'b0, s_maj1 - s_maj0} + 1'b1;
		end else if (cmd.step) begin
			maj_q    <= g_maj;
			min_q    <= g_min;
			err_q    <= g_err;
			remain_q <= remain_q - REMAIN_W'(GROUP);
		end
	end

	// Register the result item
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			lane_x_q     <= g_x;
			lane_y_q     <= g_y;
			count_q      <= g_cnt;
			colour_out_q <= colour_q;
			last_q       <= g_last;
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.step;
		end
	end

	assign lane_x       = lane_x_q;
	assign lane_y       = lane_y_q;
	assign pixel_count  = count_q;
	assign colour_out   = colour_out_q;
	assign is_last      = last_q;
	assign result_valid = valid_q;

endmodule

>>> src/bresenham_line_rasterizer_unit.sv
// Bresenham line rasterizer.
// Command channel: drive start_x/start_y/end_x/end_y/pixel_value with start high;
// the item is taken at a clock edge where start is high and busy is low.
// Result channel: result_valid strobes for one cycle per group of up to four
// pixels (lane0..lane3, pixel_count valid lanes filled from lane 0, unused
// lanes zero), with colour_out on every group and is_last set on the final one.
// Groups run from the low end of the major axis; a tie in extent makes x major.
// The command is captured at the accepting edge; the controller then passes through
// its setup state, and each run-state step registers one group onto the result ports.
// One group-stepping unit walks up to G Bresenham steps in each cycle of the run
// state, where G is the group size. busy drops in the cycle that shows the last group,
// so the next command can be taken while that group is on the result ports.
// Reset clears the controller and the strobe; no command is pending after it.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module bresenham_line_rasterizer_unit #(
	parameter int COORD_BITS = 8,
	parameter int LANES      = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  brl_pkg::coord_t   start_x,
	input  brl_pkg::coord_t   start_y,
	input  brl_pkg::coord_t   end_x,
	input  brl_pkg::coord_t   end_y,
	input  brl_pkg::colour_t  pixel_value,
	output logic              result_valid,
	output brl_pkg::coord_t   lane0_x,
	output brl_pkg::coord_t   lane0_y,
	output brl_pkg::coord_t   lane1_x,
	output brl_pkg::coord_t   lane1_y,
	output brl_pkg::coord_t   lane2_x,
	output brl_pkg::coord_t   lane2_y,
	output brl_pkg::coord_t   lane3_x,
	output brl_pkg::coord_t   lane3_y,
	output brl_pkg::count_t   pixel_count,
	output brl_pkg::colour_t  colour_out,
	output logic              is_last
);
	import brl_pkg::*;

	localparam int GROUP = brl_group(LANES);

	brl_cmd_t    cmd;
	brl_status_t status;
	coord_t      lane_x [HW_LANES];
	coord_t      lane_y [HW_LANES];

	brl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	brl_datapath #(
		.COORD_BITS (COORD_BITS),
		.LANES      (LANES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.pixel_value  (pixel_value),
		.lane_x       (lane_x),
		.lane_y       (lane_y),
		.pixel_count  (pixel_count),
		.colour_out   (colour_out),
		.is_last      (is_last),
		.result_valid (result_valid)
	);

	assign lane0_x = lane_x[0];
	assign lane0_y = lane_y[0];
	assign lane1_x = lane_x[1];
	assign lane1_y = lane_y[1];
	assign lane2_x = lane_x[2];
	assign lane2_y = lane_y[2];
	assign lane3_x = lane_x[3];
	assign lane3_y = lane_y[3];

	// Every shown group holds between one and GROUP pixels
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pixel_count != '0) && (pixel_count <= CNT_W'(GROUP)))
		else $error("pixel_count out of range");

	// Only the final group of a line may be partly filled
	a_full_groups: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_last |-> pixel_count == CNT_W'(GROUP))
		else $error("partial group before end of line");

	// The final group shows just as busy drops
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_last |-> !busy)
		else $error("busy still high with final group");

	// Groups before the final one appear only while the line is in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_last |-> busy)
		else $error("intermediate group while idle");

	// An accepted command always turns busy on
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

endmodule

>>> dv/line_pixel_checker.sv
module line_pixel_checker #(
	parameter int COORD_BITS = 8,
	parameter int LANES      = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  brl_pkg::coord_t  start_x,
	input  brl_pkg::coord_t  start_y,
	input  brl_pkg::coord_t  end_x,
	input  brl_pkg::coord_t  end_y,
	input  brl_pkg::colour_t pixel_value,
	input  logic             result_valid,
	input  brl_pkg::coord_t  lane0_x,
	input  brl_pkg::coord_t  lane0_y,
	input  brl_pkg::coord_t  lane1_x,
	input  brl_pkg::coord_t  lane1_y,
	input  brl_pkg::coord_t  lane2_x,
	input  brl_pkg::coord_t  lane2_y,
	input  brl_pkg::coord_t  lane3_x,
	input  brl_pkg::coord_t  lane3_y,
	input  brl_pkg::count_t  pixel_count,
	input  brl_pkg::colour_t colour_out,
	input  logic             is_last,
	output int               fail_count,
	output int               groups_pending,
	output int               lines_seen,
	output int               groups_seen,
	output int               partial_seen
);
	import brl_pkg::*;

	localparam int COORD_MASK = (1 << COORD_BITS) - 1;
	// Pixels per group, clamped to the lanes the ports carry
	localparam int GROUP = (LANES < 1) ? 1 : ((LANES > HW_LANES) ? HW_LANES : LANES);

	typedef struct packed {
		coord_t [HW_LANES-1:0] px;
		coord_t [HW_LANES-1:0] py;
		count_t                cnt;
		colour_t               colour;
		logic                  last;
	} pixel_group_t;

	pixel_group_t pixel_groups_due[$];
	int errors    = 0;
	int n_lines   = 0;
	int n_groups  = 0;
	int n_partial = 0;

	// Walk one line and queue every pixel group it should produce
	function automatic void trace_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
		colour_t colour);
		int ax, ay, bx, by, adx, ady;
		int maj0, min0, maj1, min1, t;
		int dx, dy, err, mstep, total, done, cnt;
		bit steep;
		pixel_group_t g;
		ax = int'(sx) & COORD_MASK;
		ay = int'(sy) & COORD_MASK;
		bx = int'(ex) & COORD_MASK;
		by = int'(ey) & COORD_MASK;
		adx = (bx > ax) ? bx - ax : ax - bx;
		ady = (by > ay) ? by - ay : ay - by;
		// a tie in extent keeps x as the major axis
		steep = ady > adx;
		if (steep) begin
			maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
		end else begin
			maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
		end
		// run upward along the major axis
		if (maj0 > maj1) begin
			t = maj0; maj0 = maj1; maj1 = t;
			t = min0; min0 = min1; min1 = t;
		end
		dx    = maj1 - maj0;
		dy    = (min1 > min0) ? min1 - min0 : min0 - min1;
		mstep = (min0 < min1) ? 1 : -1;
		err   = dx / 2;
		total = dx + 1;
		done  = 0;
		while (done < total) begin
			g   = '0;
			cnt = 0;
			while (cnt < GROUP && done < total) begin
				g.px[cnt] = coord_t'(steep ? min0 : maj0);
				g.py[cnt] = coord_t'(steep ? maj0 : min0);
				cnt++;
				done++;
				err -= dy;
				if (err < 0) begin
					min0 += mstep;
					err  += dx;
				end
				maj0++;
			end
			g.cnt    = count_t'(cnt);
			g.colour = colour;
			g.last   = (done >= total);
			pixel_groups_due.insert(pixel_groups_due.size(), g);
		end
	endfunction

	task automatic compare_field(string what, int line_no, logic [31:0] want,
		logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: line %0d %s mismatch: expected %0h, actual %0h",
				$time, line_no, what, want, got);
		end
	endtask

	// Line number of each queued group, for reports
	int group_line[$];

	always @(posedge clk) begin : watch
		pixel_group_t want;
		pixel_group_t got;
		int prior_depth;
		int line_no;
		if (arst_n) begin
			// check a shown group against the oldest prediction
			if (result_valid === 1'b1) begin
				got.px     = {lane3_x, lane2_x, lane1_x, lane0_x};
				got.py     = {lane3_y, lane2_y, lane1_y, lane0_y};
				got.cnt    = pixel_count;
				got.colour = colour_out;
				got.last   = is_last;
				if (pixel_groups_due.size() == 0) begin
					errors++;
					$display({"%0t: unexpected pixel group: expected none, ",
						"actual count %0d x0 %0h y0 %0h"},
						$time, pixel_count, lane0_x, lane0_y);
				end else begin
					want    = pixel_groups_due.pop_front();
					line_no = group_line.pop_front();
					n_groups++;
					if (want.cnt != count_t'(GROUP)) n_partial++;
					for (int k = 0; k < HW_LANES; k++) begin
						compare_field($sformatf("lane%0d_x", k), line_no,
							32'(want.px[k]), 32'(got.px[k]));
						compare_field($sformatf("lane%0d_y", k), line_no,
							32'(want.py[k]), 32'(got.py[k]));
					end
					compare_field("pixel_count", line_no, 32'(want.cnt), 32'(got.cnt));
					compare_field("colour_out", line_no, want.colour, got.colour);
					compare_field("is_last", line_no, 32'(want.last), 32'(got.last));
				end
			end
			// predict the groups of an accepted line item
			if (start === 1'b1 && busy === 1'b0) begin
				prior_depth = pixel_groups_due.size();
				trace_line(start_x, start_y, end_x, end_y, pixel_value);
				for (int k = prior_depth; k < pixel_groups_due.size(); k++)
					group_line.insert(group_line.size(), n_lines);
				n_lines++;
			end
		end
		fail_count     <= errors;
		groups_pending <= pixel_groups_due.size();
		lines_seen     <= n_lines;
		groups_seen    <= n_groups;
		partial_seen   <= n_partial;
	end

endmodule

>>> dv/tb_bresenham_line_rasterizer_unit.sv
module tb_bresenham_line_rasterizer_unit;
	import brl_pkg::*;

	localparam int COORD_BITS  = 8;
	localparam int LANES       = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_LINES = 350;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	coord_t  start_x, start_y, end_x, end_y;
	colour_t pixel_value;
	logic    result_valid;
	coord_t  lane0_x, lane0_y, lane1_x, lane1_y;
	coord_t  lane2_x, lane2_y, lane3_x, lane3_y;
	count_t  pixel_count;
	colour_t colour_out;
	logic    is_last;

	int fail_count, groups_pending, lines_seen, groups_seen, partial_seen;
	int cycle_count = 0;
	bit idle_on = 1'b1;

	bresenham_line_rasterizer_unit #(
		.COORD_BITS(COORD_BITS),
		.LANES(LANES)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.pixel_value(pixel_value), .result_valid(result_valid),
		.lane0_x(lane0_x), .lane0_y(lane0_y), .lane1_x(lane1_x), .lane1_y(lane1_y),
		.lane2_x(lane2_x), .lane2_y(lane2_y), .lane3_x(lane3_x), .lane3_y(lane3_y),
		.pixel_count(pixel_count), .colour_out(colour_out), .is_last(is_last)
	);

	line_pixel_checker #(
		.COORD_BITS(COORD_BITS),
		.LANES(LANES)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.pixel_value(pixel_value), .result_valid(result_valid),
		.lane0_x(lane0_x), .lane0_y(lane0_y), .lane1_x(lane1_x), .lane1_y(lane1_y),
		.lane2_x(lane2_x), .lane2_y(lane2_y), .lane3_x(lane3_x), .lane3_y(lane3_y),
		.pixel_count(pixel_count), .colour_out(colour_out), .is_last(is_last),
		.fail_count(fail_count), .groups_pending(groups_pending),
		.lines_seen(lines_seen), .groups_seen(groups_seen), .partial_seen(partial_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bresenham_line_rasterizer_unit regression: fail");
			$finish;
		end
	end

	// Offer one line item, hold it until taken, then maybe idle
	task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, colour_t c);
		start       <= 1'b1;
		start_x     <= sx;
		start_y     <= sy;
		end_x       <= ex;
		end_y       <= ey;
		pixel_value <= c;
		do @(posedge clk); while (busy !== 1'b0);
		if (idle_on && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		coord_t sx, sy, ex, ey;
		int d;
		arst_n      = 1'b0;
		start       = 1'b0;
		start_x     = '0;
		start_y     = '0;
		end_x       = '0;
		end_y       = '0;
		pixel_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pixel lines at both corners
		send_line(8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_0000);
		send_line(8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
		// horizontal and vertical runs, both directions, three of them full length
		send_line(8'd0, 8'd10, 8'd255, 8'd10, 32'hA5A5_A5A5);
		send_line(8'd200, 8'd5, 8'd3, 8'd5, 32'h5A5A_5A5A);
		send_line(8'd7, 8'd255, 8'd7, 8'd0, 32'h1234_5678);
		send_line(8'd7, 8'd0, 8'd7, 8'd255, 32'h8765_4321);
		// full and short diagonals, a tie in extent keeps x major
		send_line(8'd0, 8'd0, 8'd255, 8'd255, 32'hDEAD_BEEF);
		send_line(8'd255, 8'd0, 8'd0, 8'd255, 32'h0F0F_F0F0);
		send_line(8'd10, 8'd20, 8'd13, 8'd17, 32'h0000_0001);
		// one line per octant
		send_line(8'd0, 8'd0, 8'd200, 8'd77, 32'h8000_0000);
		send_line(8'd0, 8'd0, 8'd77, 8'd200, 32'h7FFF_FFFF);
		send_line(8'd255, 8'd0, 8'd55, 8'd77, 32'h0000_FFFF);
		send_line(8'd255, 8'd0, 8'd178, 8'd200, 32'hFFFF_0000);
		send_line(8'd200, 8'd77, 8'd0, 8'd0, 32'h3333_3333);
		send_line(8'd77, 8'd200, 8'd0, 8'd0, 32'hCCCC_CCCC);
		send_line(8'd55, 8'd77, 8'd255, 8'd0, 32'h6666_6666);
		send_line(8'd178, 8'd200, 8'd255, 8'd0, 32'h9999_9999);
		// short lines of two to five pixels, and one long diagonal
		send_line(8'd100, 8'd100, 8'd101, 8'd100, 32'h0000_0002);
		send_line(8'd100, 8'd100, 8'd102, 8'd101, 32'h0000_0003);
		send_line(8'd100, 8'd103, 8'd100, 8'd100, 32'h0000_0004);
		send_line(8'd104, 8'd98, 8'd100, 8'd100, 32'h0000_0005);
		send_line(8'd1, 8'd254, 8'd254, 8'd1, 32'hFEDC_BA98);

		// random lines: short, arbitrary, axis-aligned, diagonal and mirrored
		for (int n = 0; n < RANDOM_LINES; n++) begin
			idle_on = !(n >= 120 && n < 220);
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					ex = coord_t'(int'(sx) + $urandom_range(0, 10) - 5);
					ey = coord_t'(int'(sy) + $urandom_range(0, 10) - 5);
				end
				4, 5, 6: begin
					ex = coord_t'($urandom);
					ey = coord_t'($urandom);
				end
				7: begin
					ex = $urandom_range(0, 1) ? coord_t'($urandom) : sx;
					ey = (ex == sx) ? coord_t'($urandom) : sy;
				end
				8: begin
					d  = $urandom_range(0, 40);
					ex = coord_t'($urandom_range(0, 1) ? int'(sx) + d : int'(sx) - d);
					ey = coord_t'($urandom_range(0, 1) ? int'(sy) + d : int'(sy) - d);
				end
				default: begin
					ex = $urandom_range(0, 1) ? sx : ~sx;
					ey = (ex == sx) ? sy : ~sy;
				end
			endcase
			send_line(sx, sy, ex, ey, colour_t'($urandom));
		end
		start <= 1'b0;

		// drain the outstanding groups, then allow for the pipeline depth
		do @(posedge clk); while (groups_pending != 0);
		repeat (10) @(posedge clk);

		$display("covered %0d line items in all octants, axis-aligned and single-pixel,",
			lines_seen);
		$display("checked %0d pixel groups, %0d of them partly filled", groups_seen,
			partial_seen);
		if (fail_count == 0 && groups_pending == 0) begin
			$display("bresenham_line_rasterizer_unit regression: pass");
		end else begin
			$display("bresenham_line_rasterizer_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
src/brl_pkg.sv
src/brl_ctrl.sv
src/brl_datapath.sv
src/bresenham_line_rasterizer_unit.sv
dv/line_pixel_checker.sv
dv/tb_bresenham_line_rasterizer_unit.sv
